[design/bsdc_pkg.sv]
package bsdc_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int COORD_W        = 32;
    localparam int T_W            = 17;
    localparam int IDX_W          = 4;
    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    // one queued job handed from the loader to the engine
    typedef struct packed {
        logic [T_W-1:0] t;
        logic [5:0]     count;
        logic           ovf;
    } job_t;

    // a + round((b - a) * t), ties toward plus infinity
    function automatic logic signed [COORD_W-1:0] lerp_q16(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic [T_W-1:0] t
    );
        logic signed [COORD_W:0]   d;
        logic signed [COORD_W+T_W+1:0] p;
        logic signed [COORD_W+T_W+1:0] q;
        begin
            d = {b[COORD_W-1], b} - {a[COORD_W-1], a};
            p = d * $signed({1'b0, t}) + (COORD_W+T_W+2)'(32768);
            q = p >>> 16;
            lerp_q16 = a + q[COORD_W-1:0];
        end
    endfunction

endpackage

[design/bsdc_ram.sv]
module bsdc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[design/bsdc_front.sv]
module bsdc_front #(
    parameter int MAX_POINTS = bsdc_pkg::MAX_POINTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [31:0]                       px,
    input  logic [31:0]                       py,
    input  logic [16:0]                       tin,
    input  logic                              last,
    output logic                              we,
    output logic [$clog2(MAX_POINTS)-1:0]     waddr,
    output logic [63:0]                       wdata,
    output logic                              job_valid,
    output bsdc_pkg::job_t                    job,
    input  logic                              job_ready
);
    import bsdc_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);

    logic [5:0] cnt_reg, cnt_next;
    logic       ovf_reg, ovf_next;
    logic       jv_reg, jv_next;
    job_t       job_reg, job_next;
    logic       acc, room;
    logic [T_W-1:0] tsat;

    // a curve's buffer is busy while its job waits for the engine
    assign in_ready = !jv_reg;
    assign acc      = in_valid && in_ready;
    assign room     = cnt_reg < 6'(MAX_POINTS);
    assign we       = acc && room;
    assign waddr    = cnt_reg[AW-1:0];
    assign wdata    = {py, px};
    assign tsat     = (tin > T_ONE) ? T_ONE : tin;
    assign job_valid = jv_reg;
    assign job       = job_reg;

    // point count, drop flag and job slot
    always_comb
    begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        jv_next  = jv_reg;
        job_next = job_reg;
        if (jv_reg && job_ready)
        begin
            jv_next = 1'b0;
        end
        if (acc)
        begin
            if (room)
            begin
                cnt_next = cnt_reg + 6'd1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
            if (last)
            begin
                jv_next       = 1'b1;
                job_next.t     = tsat;
                job_next.count = room ? cnt_reg + 6'd1 : cnt_reg;
                job_next.ovf   = ovf_reg || !room;
                cnt_next      = '0;
                ovf_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            jv_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            jv_reg  <= jv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end
endmodule

[design/bsdc_back.sv]
module bsdc_back #(
    parameter int MAX_POINTS = bsdc_pkg::MAX_POINTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    input  bsdc_pkg::job_t                job,
    output logic                          job_ready,
    output logic [$clog2(MAX_POINTS)-1:0] raddr,
    input  logic [63:0]                   rdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          half,
    output logic [3:0]                    point_index,
    output logic [31:0]                   coord_x,
    output logic [31:0]                   coord_y,
    output logic                          overflowed,
    output logic                          last_result
);
    import bsdc_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_CALC = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;

    logic [2:0] st_reg, st_next;
    logic [31:0] wx_reg [MAX_POINTS];
    logic [31:0] wy_reg [MAX_POINTS];
    logic [31:0] lx_reg [MAX_POINTS];
    logic [31:0] ly_reg [MAX_POINTS];
    logic [31:0] ux_reg [MAX_POINTS];
    logic [31:0] uy_reg [MAX_POINTS];
    job_t        job_reg;
    logic [5:0]  i_reg, i_next;
    logic [5:0]  k_reg, k_next;
    logic [5:0]  j_reg, j_next;
    logic        rv_reg;
    logic [5:0]  n;
    logic        ov_reg, ov_next;
    logic        h_reg, h_next;
    logic [5:0]  e_reg, e_next;
    logic [31:0] nx, ny;

    assign n         = job_reg.count;
    assign job_ready = (st_reg == S_IDLE);
    assign raddr     = i_reg[AW-1:0];

    // one shared interpolator pair, one lerp per cycle
    assign nx = lerp_q16(wx_reg[j_reg[AW-1:0]], wx_reg[j_reg[AW-1:0] + AW'(1)], job_reg.t);
    assign ny = lerp_q16(wy_reg[j_reg[AW-1:0]], wy_reg[j_reg[AW-1:0] + AW'(1)], job_reg.t);

    // sequencer: load, triangle, emit
    always_comb
    begin
        st_next = st_reg;
        i_next  = i_reg;
        k_next  = k_reg;
        j_next  = j_reg;
        ov_next = ov_reg;
        h_next  = h_reg;
        e_next  = e_reg;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        unique case (st_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    st_next = S_LOAD;
                    i_next  = '0;
                end
            end
            S_LOAD:
            begin
                i_next = i_reg + 6'd1;
                if (i_reg == job_reg.count)
                begin
                    st_next = S_CALC;
                    k_next  = 6'd1;
                    j_next  = '0;
                end
            end
            S_CALC:
            begin
                if (k_reg >= n)
                begin
                    st_next = S_EMIT;
                    h_next  = 1'b0;
                    e_next  = '0;
                end
                else if (j_reg + 6'd1 >= n - k_reg)
                begin
                    j_next = '0;
                    k_next = k_reg + 6'd1;
                end
                else
                begin
                    j_next = j_reg + 6'd1;
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    if (e_reg + 6'd1 == n)
                    begin
                        e_next = '0;
                        h_next = 1'b1;
                        if (h_reg)
                        begin
                            st_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        e_next = e_reg + 6'd1;
                    end
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
            rv_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
            rv_reg <= (st_reg == S_LOAD) && (i_reg < job_reg.count);
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        k_reg <= k_next;
        j_reg <= j_next;
        h_reg <= h_next;
        e_reg <= e_next;
        if (st_reg == S_IDLE && job_valid)
        begin
            job_reg <= job;
        end
        if (rv_reg)
        begin
            wx_reg[AW'(i_reg - 6'd1)] <= rdata[31:0];
            wy_reg[AW'(i_reg - 6'd1)] <= rdata[63:32];
            if (i_reg == 6'd1)
            begin
                lx_reg[0] <= rdata[31:0];
                ly_reg[0] <= rdata[63:32];
            end
            if (i_reg == job_reg.count)
            begin
                ux_reg[AW'(i_reg - 6'd1)] <= rdata[31:0];
                uy_reg[AW'(i_reg - 6'd1)] <= rdata[63:32];
            end
        end
        if (st_reg == S_CALC && k_reg < n)
        begin
            wx_reg[j_reg[AW-1:0]] <= nx;
            wy_reg[j_reg[AW-1:0]] <= ny;
            if (j_reg == 6'd0)
            begin
                lx_reg[k_reg[AW-1:0]] <= nx;
                ly_reg[k_reg[AW-1:0]] <= ny;
            end
            if (j_reg + 6'd1 == n - k_reg)
            begin
                ux_reg[j_reg[AW-1:0]] <= nx;
                uy_reg[j_reg[AW-1:0]] <= ny;
            end
        end
        if (st_reg == S_EMIT && (!ov_reg || out_ready))
        begin
            half        <= h_reg;
            point_index <= e_reg[3:0];
            coord_x     <= h_reg ? ux_reg[e_reg[AW-1:0]] : lx_reg[e_reg[AW-1:0]];
            coord_y     <= h_reg ? uy_reg[e_reg[AW-1:0]] : ly_reg[e_reg[AW-1:0]];
            overflowed  <= job_reg.ovf;
            last_result <= h_reg && (e_reg + 6'd1 == n);
        end
    end

    assign out_valid = ov_reg;
endmodule

[design/bezier_subdivide_de_casteljau.sv]
// output: one word a cycle while out_ready is held high
// throughput: one point a cycle while loading and no job waits for the engine; the engine's
// pace is set by its single shared interpolator
// the loader takes the next curve while the engine still works on the previous one
// reset: asynchronous active low, clears counts, job slot and sequencer; the store is not cleared
module bezier_subdivide_de_casteljau #(
    parameter int MAX_POINTS = bsdc_pkg::MAX_POINTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] point_x,
    input  logic [31:0] point_y,
    input  logic [16:0] split_param,
    input  logic        last_point,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        half,
    output logic [3:0]  point_index,
    output logic [31:0] coord_x,
    output logic [31:0] coord_y,
    output logic        overflowed,
    output logic        last_result
);
    import bsdc_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0]   wdata, rdata;
    logic          job_valid, job_ready;
    job_t          job;

    bsdc_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .px(point_x), .py(point_y), .tin(split_param), .last(last_point),
        .we(we), .waddr(waddr), .wdata(wdata),
        .job_valid(job_valid), .job(job), .job_ready(job_ready)
    );

    bsdc_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_store (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    bsdc_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job(job), .job_ready(job_ready),
        .raddr(raddr), .rdata(rdata), .out_valid(out_valid), .out_ready(out_ready),
        .half(half), .point_index(point_index), .coord_x(coord_x), .coord_y(coord_y),
        .overflowed(overflowed), .last_result(last_result)
    );

`ifndef SYNTHESIS
    // the final word always belongs to the upper half
    a_last_upper: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_result |-> half)
        else $error("last word not in upper half");

    // loader blocks while a job waits
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> !in_ready)
        else $error("loader open with pending job");
`endif
endmodule

[tb/sv/bezier_subdivide_de_casteljau_tb.sv]
`timescale 1ns / 1ps

module bezier_subdivide_de_casteljau_tb;

    localparam int NPTS = 16;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [16:0] tp;
        logic        lastp;
    } point_word_t;

    typedef struct {
        logic        hf;
        logic [3:0]  idx;
        logic [31:0] cx;
        logic [31:0] cy;
        logic        ovf;
        logic        lst;
    } subcurve_word_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [16:0] split_param;
    logic        last_point;
    logic        out_valid;
    logic        out_ready;
    logic        half;
    logic [3:0]  point_index;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic        overflowed;
    logic        last_result;

    bezier_subdivide_de_casteljau dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .point_x(point_x), .point_y(point_y),
        .split_param(split_param), .last_point(last_point),
        .out_valid(out_valid), .out_ready(out_ready),
        .half(half), .point_index(point_index),
        .coord_x(coord_x), .coord_y(coord_y),
        .overflowed(overflowed), .last_result(last_result)
    );

    point_word_t    pending_points[$];
    subcurve_word_t expected_words[$];

    // shadow of the point store
    logic signed [31:0] held_x[NPTS];
    logic signed [31:0] held_y[NPTS];
    int                 held_count;
    logic               held_ovf;

    int  error_count;
    int  cycle_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  hold_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    // rounded interpolation a + (b - a) * t, ties toward plus infinity
    function automatic logic signed [31:0] blend(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input longint t);
        longint d;
        d = (longint'(b) - longint'(a)) * t + 32768;
        return 32'(longint'(a) + (d >>> 16));
    endfunction

    // apply one accepted word to the shadow, queue the sub-curve words it causes
    task automatic predict_subdivision(input point_word_t w);
        logic signed [31:0] wx[NPTS], wy[NPTS];
        logic signed [31:0] lx[NPTS], ly[NPTS], ux[NPTS], uy[NPTS];
        longint t;
        int n;
        subcurve_word_t e;
        if (held_count < NPTS)
        begin
            held_x[held_count] = w.px;
            held_y[held_count] = w.py;
            held_count++;
        end
        else
            held_ovf = 1'b1;
        if (!w.lastp)
            return;
        t = (w.tp > 17'h10000) ? 65536 : longint'(w.tp);
        n = held_count;
        for (int j = 0; j < n; j++)
        begin
            wx[j] = held_x[j];
            wy[j] = held_y[j];
        end
        lx[0] = wx[0]; ly[0] = wy[0];
        ux[n-1] = wx[n-1]; uy[n-1] = wy[n-1];
        for (int k = 1; k < n; k++)
        begin
            for (int j = 0; j < n - k; j++)
            begin
                wx[j] = blend(wx[j], wx[j+1], t);
                wy[j] = blend(wy[j], wy[j+1], t);
            end
            lx[k] = wx[0]; ly[k] = wy[0];
            ux[n-1-k] = wx[n-1-k]; uy[n-1-k] = wy[n-1-k];
        end
        for (int h = 0; h < 2; h++)
            for (int j = 0; j < n; j++)
            begin
                e.hf  = h[0];
                e.idx = j[3:0];
                e.cx  = h ? ux[j] : lx[j];
                e.cy  = h ? uy[j] : ly[j];
                e.ovf = held_ovf;
                e.lst = (h == 1) && (j == n - 1);
                expected_words.push_back(e);
            end
        held_count = 0;
        held_ovf = 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'(int'($urandom_range(0, 4000)) - 2000) <<< 16;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [16:0] rand_split();
        case ($urandom_range(0, 7))
            0: return 17'h0;
            1: return 17'h10000;
            2: return 17'h10000 + 17'($urandom_range(1, 65535));
            3: return 17'h8000;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic queue_curve(input int n, input logic [16:0] tp);
        point_word_t w;
        for (int i = 0; i < n; i++)
        begin
            w.px = rand_coord();
            w.py = rand_coord();
            w.tp = (i == n - 1) ? tp : 17'($urandom());
            w.lastp = (i == n - 1);
            pending_points.push_back(w);
        end
    endtask

    task automatic queue_word(input logic [31:0] x, input logic [31:0] y,
                              input logic [16:0] tp, input logic lp);
        point_word_t w;
        w.px = x; w.py = y; w.tp = tp; w.lastp = lp;
        pending_points.push_back(w);
    endtask

    task automatic wait_drained();
        while (pending_points.size() != 0 || expected_words.size() != 0)
            @(posedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            point_x     <= '0;
            point_y     <= '0;
            split_param <= '0;
            last_point  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_subdivision(pending_points.pop_front());
            end
            if (!(in_valid && !in_ready))
            begin
                if (pending_points.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid    <= 1'b1;
                    point_x     <= pending_points[0].px;
                    point_y     <= pending_points[0].py;
                    split_param <= pending_points[0].tp;
                    last_point  <= pending_points[0].lastp;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and ready generation
    always @(posedge clk or negedge rst_n)
    begin
        subcurve_word_t e;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    report_mismatch("unexpected word index", 32'(point_index), 32'(0));
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (half !== e.hf) report_mismatch("half", 32'(half), 32'(e.hf));
                    if (point_index !== e.idx)
                        report_mismatch("point_index", 32'(point_index), 32'(e.idx));
                    if (coord_x !== e.cx) report_mismatch("coord_x", coord_x, e.cx);
                    if (coord_y !== e.cy) report_mismatch("coord_y", coord_y, e.cy);
                    if (overflowed !== e.ovf)
                        report_mismatch("overflowed", 32'(overflowed), 32'(e.ovf));
                    if (last_result !== e.lst)
                        report_mismatch("last_result", 32'(last_result), 32'(e.lst));
                end
            end
            if (hold_off)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off, counted in its own process
    always @(posedge clk)
    begin
        if (hold_off)
        begin
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= 400)
                hold_off <= 1'b0;
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int n;
        error_count = 0;
        cycle_count = 0;
        held_count = 0;
        held_ovf = 1'b0;
        hold_off = 1'b0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: single point, extremes, split saturation, overflow
        queue_word(32'h7fffffff, 32'h80000000, 17'h8000, 1'b1);
        queue_word(32'h80000000, 32'h7fffffff, 17'h0, 1'b0);
        queue_word(32'h7fffffff, 32'h80000000, 17'h1ffff, 1'b1);
        queue_word(32'hffffffff, 32'h00000001, 17'h0, 1'b0);
        queue_word(32'h00000000, 32'hfffffffe, 17'h10000, 1'b0);
        queue_word(32'h00010000, 32'h00000003, 17'h08000, 1'b1);
        queue_word(32'h00000001, 32'h00000000, 17'h10001, 1'b0);
        queue_word(32'h00000000, 32'h00000001, 17'h08000, 1'b1);
        queue_curve(17, 17'h04000);
        wait_drained();

        // random curves across idling phases
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                3: begin send_idle_pct = 21; recv_stall_pct = 21; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 4)
            begin
                hold_cycles = 0;
                hold_off = 1'b1;
            end
            for (int c = 0; c < 12; c++)
            begin
                case ($urandom_range(0, 9))
                    0: n = 1;
                    1: n = 16;
                    2: n = $urandom_range(17, 19);
                    default: n = $urandom_range(2, 7);
                endcase
                queue_curve(n, rand_split());
            end
            wait_drained();
        end

        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[bezier_subdivide_de_casteljau.f]
design/bsdc_pkg.sv
design/bsdc_ram.sv
design/bsdc_front.sv
design/bsdc_back.sv
design/bezier_subdivide_de_casteljau.sv
tb/sv/bezier_subdivide_de_casteljau_tb.sv
